// File: rtl/zero_crossing_interp_mean_defines.svh
// ----------------------------------------------------------------------------
// Zero crossing interpolation mean - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_INTERP_MEAN_DEFINES_SVH
`define ZERO_CROSSING_INTERP_MEAN_DEFINES_SVH

// condition implies consequence in the same cycle
`define ZCIM_ASSERT_SAME(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define ZCIM_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/zcim_pkg.sv
// ----------------------------------------------------------------------------
// Zero crossing interpolation mean - package
// Fixed widths and constants of the crossing datapath.
// ----------------------------------------------------------------------------
package zcim_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 12;
    localparam int STEP_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [STEP_W-1:0]  DIV_STEPS = 5'd17;

endpackage

// File: rtl/zero_crossing_interp_mean.sv
// ----------------------------------------------------------------------------
// Zero crossing interpolation mean
// Interpolates velocity at negative-to-positive level crossings and reports
// the mean of the crossings at the end of each run.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one sample transaction carries velocity,
// level_value and last_sample. Output channel (out_valid/out_ready): one
// result transaction per sample, in order.
// A sample is taken only while the sequencer is idle. One shared restoring
// divider (one quotient bit per cycle) forms both the interpolated value and
// the run mean; a 16x16 multiplier feeds it.
// Steps per sample from accept: S_CHECK; for a crossing, S_LOAD and the
// interpolating division in S_DIV, then S_INTERP; S_MEAN, where the last
// sample of a run with crossings counted runs the mean division in S_DIV
// and S_MEAN_DONE; then S_OUT, which loads the result.
// in_ready rises at the edge that loads the result and the next sample is
// taken at the following edge.
// A finished result sits in the output register; the next sample is taken
// and worked on meanwhile, and only the final load waits for out_ready.
// Reset clears the sequencer, the run sum, the count and the previous
// sample, so the first sample after reset starts a run.
// ----------------------------------------------------------------------------
`include "zero_crossing_interp_mean_defines.svh"

module zero_crossing_interp_mean (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  velocity,
    input  logic signed [15:0]  level_value,
    input  logic                last_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                crossing_found,
    output logic signed [15:0]  surface_value,
    output logic                run_done,
    output logic signed [15:0]  mean_value,
    output logic [11:0]         crossing_count,
    output logic                no_crossing
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_DIV,
        S_INTERP,
        S_MEAN,
        S_MEAN_DONE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [15:0] vel_reg, vel_next;
    logic signed [15:0] lvl_reg, lvl_next;
    logic               last_reg, last_next;

    logic signed [15:0] prev_vel_reg, prev_vel_next;
    logic signed [15:0] prev_lvl_reg, prev_lvl_next;
    logic               have_prev_reg, have_prev_next;
    logic signed [27:0] sum_reg, sum_next;
    logic [11:0]        total_reg, total_next;

    logic               hit_reg, hit_next;
    logic signed [15:0] surf_reg, surf_next;
    logic signed [15:0] mean_reg, mean_next;

    logic [31:0]        prod_reg, prod_next;
    logic [16:0]        rem_reg, rem_next;
    logic [16:0]        num_reg, num_next;
    logic [16:0]        quo_reg, quo_next;
    logic [16:0]        dvs_reg, dvs_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               div_mean_reg, div_mean_next;

    logic               out_valid_reg, out_valid_next;
    logic               found_o_reg, found_o_next;
    logic signed [15:0] surf_o_reg, surf_o_next;
    logic               done_o_reg, done_o_next;
    logic signed [15:0] mean_o_reg, mean_o_next;
    logic [11:0]        count_o_reg, count_o_next;
    logic               none_o_reg, none_o_next;

    logic               crossing;
    logic signed [16:0] dv;
    logic [16:0]        dv_abs;
    logic [16:0]        l0_neg;
    logic [16:0]        d_full;
    logic [32:0]        interp_num;
    logic [27:0]        sum_abs;
    logic [32:0]        mean_num;
    logic [17:0]        trial;
    logic               ge;
    logic signed [17:0] q_signed;
    logic signed [17:0] surf_full;
    logic [16:0]        mean_full;
    logic               out_free;

    always_comb
    begin
        crossing   = have_prev_reg && (prev_lvl_reg < 0) && (lvl_reg > 0);
        dv         = {vel_reg[15], vel_reg} - {prev_vel_reg[15], prev_vel_reg};
        dv_abs     = dv[16] ? 17'(-dv) : 17'(dv);
        l0_neg     = 17'(-{prev_lvl_reg[15], prev_lvl_reg});
        d_full     = 17'({lvl_reg[15], lvl_reg} - {prev_lvl_reg[15], prev_lvl_reg});
        interp_num = {prod_reg, 1'b0} + {17'd0, dvs_reg[16:1]};
        sum_abs    = sum_reg[27] ? 28'(-sum_reg) : 28'(sum_reg);
        mean_num   = {5'd0, sum_abs[26:0], 1'b0} + {21'd0, total_reg};
        trial      = {rem_reg, num_reg[16]};
        ge         = trial >= {1'b0, dvs_reg};
        q_signed   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        surf_full  = {{2{prev_vel_reg[15]}}, prev_vel_reg} + q_signed;
        mean_full  = neg_reg ? 17'(-quo_reg) : quo_reg;
        out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        vel_next       = vel_reg;
        lvl_next       = lvl_reg;
        last_next      = last_reg;
        prev_vel_next  = prev_vel_reg;
        prev_lvl_next  = prev_lvl_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        hit_next       = hit_reg;
        surf_next      = surf_reg;
        mean_next      = mean_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        div_mean_next  = div_mean_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_o_next   = found_o_reg;
        surf_o_next    = surf_o_reg;
        done_o_next    = done_o_reg;
        mean_o_next    = mean_o_reg;
        count_o_next   = count_o_reg;
        none_o_next    = none_o_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    vel_next   = velocity;
                    lvl_next   = level_value;
                    last_next  = last_sample;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                hit_next  = 1'b0;
                surf_next = '0;
                mean_next = '0;
                if (crossing)
                begin
                    prod_next     = dv_abs[15:0] * l0_neg[15:0];
                    dvs_next      = {d_full[15:0], 1'b0};
                    neg_next      = dv[16];
                    div_mean_next = 1'b0;
                    state_next    = S_LOAD;
                end
                else
                begin
                    state_next = S_MEAN;
                end
            end
            S_LOAD:
            begin
                rem_next   = {1'b0, interp_num[32:17]};
                num_next   = interp_num[16:0];
                cnt_next   = zcim_pkg::DIV_STEPS;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? 17'(trial - {1'b0, dvs_reg}) : trial[16:0];
                quo_next = {quo_reg[15:0], ge};
                num_next = {num_reg[15:0], 1'b0};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = div_mean_reg ? S_MEAN_DONE : S_INTERP;
                end
            end
            S_INTERP:
            begin
                hit_next  = 1'b1;
                surf_next = surf_full[15:0];
                if (total_reg != zcim_pkg::COUNT_MAX)
                begin
                    total_next = total_reg + 12'd1;
                    sum_next   = sum_reg + {{12{surf_full[15]}}, surf_full[15:0]};
                end
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                if (last_reg && (total_reg != '0))
                begin
                    rem_next      = {1'b0, mean_num[32:17]};
                    num_next      = mean_num[16:0];
                    dvs_next      = {4'd0, total_reg, 1'b0};
                    neg_next      = sum_reg[27];
                    cnt_next      = zcim_pkg::DIV_STEPS;
                    div_mean_next = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MEAN_DONE:
            begin
                mean_next  = mean_full[15:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_o_next   = hit_reg;
                    surf_o_next    = surf_reg;
                    done_o_next    = last_reg;
                    mean_o_next    = mean_reg;
                    count_o_next   = total_reg;
                    none_o_next    = last_reg && (total_reg == '0);
                    prev_vel_next  = vel_reg;
                    prev_lvl_next  = lvl_reg;
                    have_prev_next = !last_reg;
                    if (last_reg)
                    begin
                        sum_next   = '0;
                        total_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vel_reg       <= '0;
            lvl_reg       <= '0;
            last_reg      <= 1'b0;
            prev_vel_reg  <= '0;
            prev_lvl_reg  <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            total_reg     <= '0;
            hit_reg       <= 1'b0;
            surf_reg      <= '0;
            mean_reg      <= '0;
            prod_reg      <= '0;
            rem_reg       <= '0;
            num_reg       <= '0;
            quo_reg       <= '0;
            dvs_reg       <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            div_mean_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_o_reg   <= 1'b0;
            surf_o_reg    <= '0;
            done_o_reg    <= 1'b0;
            mean_o_reg    <= '0;
            count_o_reg   <= '0;
            none_o_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vel_reg       <= vel_next;
            lvl_reg       <= lvl_next;
            last_reg      <= last_next;
            prev_vel_reg  <= prev_vel_next;
            prev_lvl_reg  <= prev_lvl_next;
            have_prev_reg <= have_prev_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            hit_reg       <= hit_next;
            surf_reg      <= surf_next;
            mean_reg      <= mean_next;
            prod_reg      <= prod_next;
            rem_reg       <= rem_next;
            num_reg       <= num_next;
            quo_reg       <= quo_next;
            dvs_reg       <= dvs_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            div_mean_reg  <= div_mean_next;
            out_valid_reg <= out_valid_next;
            found_o_reg   <= found_o_next;
            surf_o_reg    <= surf_o_next;
            done_o_reg    <= done_o_next;
            mean_o_reg    <= mean_o_next;
            count_o_reg   <= count_o_next;
            none_o_reg    <= none_o_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign crossing_found = found_o_reg;
    assign surface_value  = surf_o_reg;
    assign run_done       = done_o_reg;
    assign mean_value     = mean_o_reg;
    assign crossing_count = count_o_reg;
    assign no_crossing    = none_o_reg;

    // divider remainder stays below the divisor
    `ZCIM_ASSERT_SAME(a_div_rem, state_reg == S_DIV, rem_reg < dvs_reg, "divider remainder overflow")
    `ZCIM_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "sample taken while busy")
    `ZCIM_ASSERT_SAME(a_none_mean, out_valid && no_crossing, run_done && (mean_value == 16'sd0),
        "empty run reported a mean")
    `ZCIM_ASSERT_SAME(a_mid_run, out_valid && !run_done, (mean_value == 16'sd0) && !no_crossing,
        "mean reported before run end")

endmodule
